### sv/tatt_pkg.sv
// Package: constants and types for the thermistor ADC to temperature block.
`default_nettype none
package tatt_pkg;
  localparam int TableDepth = 128;
  localparam int TabAw      = $clog2(TableDepth);
  localparam int WindowLen  = 15;
  localparam int WinAw      = $clog2(WindowLen);
  localparam int SettleSkip = 5;

  localparam int ResW  = 24;
  localparam int TempW = 12;
  localparam int CodeW = 16;

  localparam logic signed [ResW-1:0] ResMax = 24'sh7FFFFF;
  localparam logic signed [ResW-1:0] ResMin = 24'sh800000;

  localparam logic [1:0] ModeWrRes  = 2'd0;
  localparam logic [1:0] ModeWrTemp = 2'd1;
  localparam logic [1:0] ModeSample = 2'd2;

  localparam logic [1:0] CfgLow      = 2'd0;
  localparam logic [1:0] CfgHigh     = 2'd1;
  localparam logic [1:0] CfgVeryLow  = 2'd2;
  localparam logic [1:0] CfgVeryHigh = 2'd3;
endpackage
`default_nettype wire

### sv/thermistor_adc_to_temperature.sv
// Top level: thermistor ADC sample to temperature with table lookup and peak window.
//
// Input channel in_valid_i / in_stall_o carries table-load items (mode 0/1)
// and samples (mode 2). Each sample gives one result on out_valid_o /
// out_stall_i; table loads and mode 3 give none. Configuration writes go in
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must make them only
// while the block is idle, as the block itself does not enforce it. A sample
// runs the resistance divide (one quotient bit per cycle, 46-bit dividend),
// the search over the table entries (up to k + 2 reads of the resistance
// memory, one port), the temperature read, then on a window wrap a peak scan
// of the window slots from the settle skip on, and the BCD step. The
// resistance memory port and the search set the worst case per sample.
// Results sit in an output register; the block takes the next item only
// after the previous result is transferred, so a stalled receiver holds the
// result and stalls the input. Reset clears the window (15 flip-flop slots
// read in scan order) and the slot pointer and loads the limit defaults;
// table memories hold garbage until written.
`default_nettype none
module thermistor_adc_to_temperature
  import tatt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              mode_i,
  input  wire logic [6:0]              table_index_i,
  input  wire logic signed [ResW-1:0]  table_value_i,
  input  wire logic signed [CodeW-1:0] adc_code_i,
  input  wire logic                    accumulate_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [TempW-1:0]      instant_temp_o,
  output logic signed [ResW-1:0]       resistance_o,
  output logic                         window_done_o,
  output logic [10:0]                  report_temp_o,
  output logic [4:0]                   tens_digit_o,
  output logic [3:0]                   ones_digit_o,
  output logic [3:0]                   tenths_digit_o,
  output logic [1:0]                   alarm_level_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [11:0]             cfg_data_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SRD, S_SCMP, S_NRD, S_NCMP, S_TRD, S_TWAIT,
    S_SCAN, S_BCD, S_OUT
  } state_e;

  localparam int DivW = 46;  // signed numerator times 1024 fits here
  localparam int DenW = 24;

  state_e state_q;
  logic signed [ResW-1:0] res_mem [TableDepth];
  logic signed [TempW-1:0] tmp_mem [TableDepth];
  logic signed [ResW-1:0] res_rd_q;
  logic signed [TempW-1:0] tmp_rd_q;
  logic [TabAw-1:0] raddr;
  logic signed [TempW-1:0] win_q [WindowLen];
  logic [WinAw-1:0] slot_q;
  logic signed [TempW-1:0] lo_q, hi_q, vlo_q, vhi_q;

  logic [DivW-1:0] num_q;     // magnitude of numerator, shifted out
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic [5:0]      bit_q;
  logic signed [ResW+1:0] rt_q;  // resistance, saturated
  logic [TabAw:0] k_q;
  logic signed [ResW-1:0] rk_q;
  logic            take_next_q;
  logic [WinAw-1:0] scan_q;
  logic signed [TempW-1:0] mx_q, t_q;
  logic            acc_q, done_q;
  logic [10:0]     rep_q;
  logic [3:0]      bcd_cnt_q;
  logic [10:0]     bin_q;
  logic [4:0]      d2_q;
  logic [3:0]      d1_q, d0_q;
  logic [1:0]      alarm_q;

  // numerator and divisor from the code
  logic signed [25:0] n_w, d_w;
  assign n_w = 26'sd2587200 - 26'(adc_code_i) * 26'sd111;
  assign d_w = 26'(adc_code_i) * 26'sd74 + 26'sd1176000;

  logic [DenW:0] rem_sh;
  logic [DenW:0] rem_sub;
  assign rem_sh  = {rem_q[DenW-1:0], num_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // unsigned quotient lands in num_q low bits after DivW shifts
  logic signed [DivW+1:0] q_s;
  logic signed [DivW+1:0] q_adj;
  always_comb begin
    q_s = $signed({2'b00, num_q});
    if (neg_q) q_s = -q_s - ((rem_q != '0) ? 48'sd1 : 48'sd0);
    q_adj = q_s - 48'sd1024;
  end

  logic signed [ResW+1:0] span_w, off_w;
  assign span_w = 26'(rk_q) - 26'(res_rd_q);
  assign off_w  = rt_q - 26'(rk_q);

  always_comb begin
    unique case (state_q)
      S_SRD, S_SCMP: raddr = k_q[TabAw-1:0];
      default:       raddr = TabAw'(k_q + 1'b1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && mode_i == ModeWrRes)
      res_mem[table_index_i] <= table_value_i;
    if (in_valid_i && !in_stall_o && mode_i == ModeWrTemp)
      tmp_mem[table_index_i] <= table_value_i[TempW-1:0];
    res_rd_q <= res_mem[raddr];
    tmp_rd_q <= tmp_mem[take_next_q ? TabAw'(k_q + 1'b1) : k_q[TabAw-1:0]];
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q <= '0;
      for (int i = 0; i < WindowLen; i++) win_q[i] <= '0;
      lo_q <= 12'sd350; hi_q <= 12'sd375; vlo_q <= 12'sd340; vhi_q <= 12'sd390;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLow:      lo_q  <= cfg_data_i;
          CfgHigh:     hi_q  <= cfg_data_i;
          CfgVeryLow:  vlo_q <= cfg_data_i;
          CfgVeryHigh: vhi_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_valid_i && mode_i == ModeSample) begin
          acc_q <= accumulate_i;
          k_q <= '0;
          take_next_q <= 1'b0;
          if (d_w <= 0) begin
            rt_q <= 26'(ResMax);
            state_q <= S_SRD;
          end else begin
            neg_q <= n_w[25];
            num_q <= DivW'(n_w[25] ? -n_w : n_w) << 10;
            den_q <= d_w[DenW-1:0];
            rem_q <= '0;
            bit_q <= 6'(DivW);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_q == 0) begin
            if (q_adj > 48'(ResMax)) rt_q <= 26'(ResMax);
            else if (q_adj < 48'(ResMin)) rt_q <= 26'(ResMin);
            else rt_q <= 26'(q_adj);
            state_q <= S_SRD;
          end else begin
            if (!rem_sub[DenW]) begin
              rem_q <= rem_sub;
              num_q <= {num_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              num_q <= {num_q[DivW-2:0], 1'b0};
            end
            bit_q <= bit_q - 1'b1;
          end
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          if (rt_q >= 26'(res_rd_q)) begin
            rk_q <= res_rd_q;
            if (k_q >= (TabAw+1)'(TableDepth - 1)) begin
              k_q <= (TabAw+1)'(TableDepth - 1);
              state_q <= S_TRD;
            end else state_q <= S_NRD;
          end else if (k_q >= (TabAw+1)'(TableDepth - 1)) begin
            k_q <= (TabAw+1)'(TableDepth - 1);
            state_q <= S_TRD;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_NRD: state_q <= S_NCMP;
        S_NCMP: begin
          take_next_q <= (2 * off_w > span_w);
          state_q <= S_TRD;
        end
        S_TRD: state_q <= S_TWAIT;
        S_TWAIT: begin
          t_q <= tmp_rd_q;
          win_q[slot_q] <= tmp_rd_q;
          alarm_q <= '0;
          mx_q <= '0;
          scan_q <= WinAw'(SettleSkip);
          bcd_cnt_q <= '0;
          if (acc_q && slot_q == WinAw'(WindowLen - 1)) begin
            slot_q <= '0;
            state_q <= (SettleSkip < WindowLen) ? S_SCAN : S_BCD;
            done_q <= 1'b1;
            rep_q <= '0;
          end else begin
            if (acc_q) slot_q <= slot_q + 1'b1;
            done_q <= 1'b0;
            rep_q <= tmp_rd_q[TempW-1] ? '0 : 11'(tmp_rd_q);
            state_q <= S_BCD;
          end
        end
        S_SCAN: begin
          if (win_q[scan_q] > mx_q) begin
            mx_q <= win_q[scan_q];
            win_q[scan_q] <= '0;
          end
          if (scan_q == WinAw'(WindowLen - 1)) state_q <= S_BCD;
          else scan_q <= scan_q + 1'b1;
        end
        S_BCD: begin
          if (bcd_cnt_q == 0) begin
            if (done_q) begin
              rep_q <= 11'(mx_q);
              bin_q <= 11'(mx_q);
              if (mx_q < vlo_q || mx_q > vhi_q) alarm_q <= 2'd2;
              else if (mx_q < lo_q || mx_q > hi_q) alarm_q <= 2'd1;
            end else bin_q <= rep_q;
            d2_q <= '0; d1_q <= '0; d0_q <= '0;
            bcd_cnt_q <= 4'd1;
          end else if (bin_q >= 11'd100) begin
            bin_q <= bin_q - 11'd100; d2_q <= d2_q + 1'b1;
          end else if (bin_q >= 11'd10) begin
            bin_q <= bin_q - 11'd10; d1_q <= d1_q + 1'b1;
          end else begin
            d0_q <= 4'(bin_q);
            out_valid_o <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (!out_stall_i) begin
          out_valid_o <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign instant_temp_o = t_q;
  assign resistance_o   = rt_q[ResW-1:0];
  assign window_done_o  = done_q;
  assign report_temp_o  = rep_q;
  assign tens_digit_o   = d2_q;
  assign ones_digit_o   = d1_q;
  assign tenths_digit_o = d0_q;
  assign alarm_level_o  = alarm_q;

  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT) else $error("result valid outside output state");
  a_no_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_done_o) |-> alarm_level_o == 2'd0) else $error("alarm without wrap");
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < WinAw'(WindowLen)) else $error("window slot out of range");
endmodule
`default_nettype wire
